// ----- sv/mcod_pkg.sv -----
package mcod_pkg;

  // Chain capacity and stored dimension width
  localparam int MAX_MATRICES = 8;
  localparam int DIM_BITS     = 12;
  localparam int DIM_CAP      = MAX_MATRICES + 1;

  // Fixed field widths of the channels
  localparam int DIM_IN_W   = 12;
  localparam int IDX_OUT_W  = 3;
  localparam int COST_OUT_W = 40;

  // Derived index and counter widths
  localparam int IDX_W   = (MAX_MATRICES > 1) ? $clog2(MAX_MATRICES) : 1;
  localparam int DADDR_W = (DIM_CAP > 1) ? $clog2(DIM_CAP) : 1;
  localparam int CNT_W   = $clog2(DIM_CAP + 1);
  localparam int LEN_W   = $clog2(MAX_MATRICES + 2);
  localparam int CADDR_W = 2 * IDX_W;
  localparam int CELL_DEPTH = 2 ** CADDR_W;

  // Arithmetic widths: one product of three dimensions, a sum of up to n-1 of them
  localparam int PROD_W = 2 * DIM_BITS;
  localparam int TERM_W = 3 * DIM_BITS;
  localparam int COST_W = TERM_W + LEN_W;

  typedef logic [DIM_BITS-1:0] dim_t;
  typedef logic [IDX_W-1:0]    idx_t;
  typedef logic [LEN_W-1:0]    len_t;
  typedef logic [COST_W-1:0]   cost_t;

endpackage

// ----- sv/mcod_ifs.sv -----
interface mcod_in_if;
  logic                           valid;
  logic                           ready;
  logic [mcod_pkg::DIM_IN_W-1:0]  dim;
  logic                           last_dim;

  modport source (output valid, output dim, output last_dim, input ready);
  modport sink   (input valid, input dim, input last_dim, output ready);
endinterface

interface mcod_out_if;
  logic                             valid;
  logic                             ready;
  logic [mcod_pkg::IDX_OUT_W-1:0]   row;
  logic [mcod_pkg::IDX_OUT_W-1:0]   col;
  logic [mcod_pkg::IDX_OUT_W-1:0]   split_at;
  logic [mcod_pkg::COST_OUT_W-1:0]  min_cost;
  logic                             error;
  logic                             last;

  modport source (output valid, output row, output col, output split_at,
                  output min_cost, output error, output last, input ready);
  modport sink   (input valid, input row, input col, input split_at,
                  input min_cost, input error, input last, output ready);
endinterface

// ----- sv/mcod_ram.sv -----
module mcod_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write one entry, read one entry into the output register
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/matrix_chain_order_dp_core.sv -----
// Channel  Dir  Handshake     Payload
// in_i     in   valid/ready   dim, last_dim
// out_o    out  valid/ready   row, col, split_at, min_cost, error, last
//
// Loading accepts one dimension item per cycle; ready is high only while loading.
// The table fill reads the dimensions and forms their product (S_DI, S_DJ, S_DP) per cell,
// then steps S_KA, S_KB, S_KC and S_KD per split candidate through one shared multiplier
// and one 40-bit adder/comparator. Each result cell passes through S_ERD, S_ECAP and
// S_EWAIT, and a result waits in the output register as long as out_o.ready stays low.
// Reset is asynchronous and clears the sequencer and counters, not the memories.
module matrix_chain_order_dp_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  mcod_in_if.sink           in_i,
  mcod_out_if.source        out_o
);

  typedef enum logic [10:0] {
    S_LOAD  = 11'b00000000001,
    S_DI    = 11'b00000000010,
    S_DJ    = 11'b00000000100,
    S_DP    = 11'b00000001000,
    S_KA    = 11'b00000010000,
    S_KB    = 11'b00000100000,
    S_KC    = 11'b00001000000,
    S_KD    = 11'b00010000000,
    S_ERD   = 11'b00100000000,
    S_ECAP  = 11'b01000000000,
    S_EWAIT = 11'b10000000000
  } state_e;

  localparam int DW = mcod_pkg::DIM_BITS;
  localparam int IW = mcod_pkg::IDX_W;
  localparam int LW = mcod_pkg::LEN_W;
  localparam int CW = mcod_pkg::COST_W;
  localparam int PW = mcod_pkg::PROD_W;
  localparam int TW = mcod_pkg::TERM_W;
  localparam int AW = mcod_pkg::DADDR_W;
  localparam int NW = mcod_pkg::CNT_W;
  localparam int XW = mcod_pkg::CADDR_W;
  localparam int OW = mcod_pkg::IDX_OUT_W;

  state_e state_q, state_d;

  logic [NW-1:0]   cnt_q, cnt_d;
  logic            ovf_q, ovf_d;
  mcod_pkg::len_t  n_q, n_d;
  mcod_pkg::len_t  len_q, len_d;
  mcod_pkg::idx_t  i_q, i_d;
  mcod_pkg::idx_t  k_q, k_d;
  mcod_pkg::idx_t  r_q, r_d;
  mcod_pkg::idx_t  c_q, c_d;
  mcod_pkg::dim_t  dim_i_q, dim_i_d;
  logic [PW-1:0]   prod_q, prod_d;
  logic [TW-1:0]   term_q, term_d;
  mcod_pkg::cost_t left_q, left_d;
  mcod_pkg::cost_t sum_q, sum_d;
  mcod_pkg::cost_t best_q, best_d;
  mcod_pkg::idx_t  best_k_q, best_k_d;

  // Output payload registers
  logic [OW-1:0]                   row_q, row_d;
  logic [OW-1:0]                   col_q, col_d;
  logic [OW-1:0]                   split_q, split_d;
  logic [mcod_pkg::COST_OUT_W-1:0] cost_q, cost_d;
  logic                            err_q, err_d;
  logic                            last_q, last_d;

  // Memory ports
  logic            dim_we;
  logic [AW-1:0]   dim_waddr, dim_raddr;
  mcod_pkg::dim_t  dim_wdata, dim_rdata;
  logic            cell_we;
  logic [XW-1:0]   cell_waddr, cell_raddr;
  mcod_pkg::cost_t cost_wdata, cost_rdata;
  mcod_pkg::idx_t  split_rdata;

  // Shared multiplier
  logic [PW-1:0]   mul_a;
  mcod_pkg::dim_t  mul_b;
  logic [TW-1:0]   mul_p;

  // Loop indices derived from the counters
  mcod_pkg::len_t  j_full, jp1_full, kp1_full;
  mcod_pkg::idx_t  j_idx, kp1_idx;
  logic            k_first, k_last, better;
  mcod_pkg::cost_t right_cost, best_nxt;
  mcod_pkg::idx_t  best_k_nxt;

  // Load-side decode
  logic            in_acc, room, run_err;
  logic [NW-1:0]   cnt_new;
  mcod_pkg::dim_t  dim_in;

  assign in_i.ready = (state_q == S_LOAD);
  assign in_acc     = in_i.valid && in_i.ready;
  assign dim_in     = DW'(in_i.dim);
  assign room       = (cnt_q < NW'(mcod_pkg::DIM_CAP));
  assign cnt_new    = room ? (cnt_q + NW'(1)) : cnt_q;
  assign run_err    = ovf_q || !room || (cnt_new < NW'(2));

  assign jp1_full = LW'(i_q) + len_q;
  assign j_full   = jp1_full - LW'(1);
  assign j_idx    = IW'(j_full);
  assign kp1_full = LW'(k_q) + LW'(1);
  assign kp1_idx  = IW'(kp1_full);
  assign k_first  = (k_q == i_q);
  assign k_last   = (kp1_full == j_full);

  assign mul_p = {{DW{1'b0}}, mul_a} * {{PW{1'b0}}, mul_b};

  // Compare the candidate against the best split so far; the first k wins ties
  assign right_cost = k_last ? '0 : cost_rdata;
  assign better     = k_first || (sum_q < best_q);
  assign best_nxt   = better ? sum_q : best_q;
  assign best_k_nxt = better ? k_q : best_k_q;

  // Route memory addresses and multiplier operands by step
  always_comb begin
    dim_raddr  = AW'(i_q);
    cell_raddr = {r_q, c_q};
    mul_a      = prod_q;
    mul_b      = dim_rdata;
    case (state_q)
      S_DJ:    dim_raddr = AW'(jp1_full);
      S_DP:    mul_a = PW'(dim_i_q);
      S_KA: begin
        dim_raddr  = AW'(kp1_full);
        cell_raddr = {i_q, k_q};
      end
      S_KB:    cell_raddr = {kp1_idx, j_idx};
      default: ;
    endcase
  end

  assign dim_we     = in_acc && room;
  assign dim_waddr  = AW'(cnt_q);
  assign dim_wdata  = dim_in;
  assign cell_we    = (state_q == S_KD) && k_last;
  assign cell_waddr = {i_q, j_idx};
  assign cost_wdata = best_nxt;

  // Sequencer
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    ovf_d    = ovf_q;
    n_d      = n_q;
    len_d    = len_q;
    i_d      = i_q;
    k_d      = k_q;
    r_d      = r_q;
    c_d      = c_q;
    dim_i_d  = dim_i_q;
    prod_d   = prod_q;
    term_d   = term_q;
    left_d   = left_q;
    sum_d    = sum_q;
    best_d   = best_q;
    best_k_d = best_k_q;
    row_d    = row_q;
    col_d    = col_q;
    split_d  = split_q;
    cost_d   = cost_q;
    err_d    = err_q;
    last_d   = last_q;
    case (state_q)
      S_LOAD: begin
        if (in_acc) begin
          if (in_i.last_dim) begin
            cnt_d = '0;
            ovf_d = 1'b0;
            if (run_err) begin
              row_d   = '0;
              col_d   = '0;
              split_d = '0;
              cost_d  = '0;
              err_d   = 1'b1;
              last_d  = 1'b1;
              state_d = S_EWAIT;
            end else begin
              n_d     = LW'(cnt_new - NW'(1));
              len_d   = LW'(2);
              i_d     = '0;
              r_d     = '0;
              c_d     = '0;
              state_d = (cnt_new == NW'(2)) ? S_ERD : S_DI;
            end
          end else begin
            cnt_d = cnt_new;
            ovf_d = ovf_q || !room;
          end
        end
      end
      S_DI: state_d = S_DJ;
      S_DJ: begin
        dim_i_d = dim_rdata;
        k_d     = i_q;
        state_d = S_DP;
      end
      S_DP: begin
        prod_d  = mul_p[PW-1:0];
        state_d = S_KA;
      end
      S_KA: state_d = S_KB;
      S_KB: begin
        term_d  = mul_p;
        left_d  = k_first ? '0 : cost_rdata;
        state_d = S_KC;
      end
      S_KC: begin
        sum_d   = left_q + right_cost + CW'(term_q);
        state_d = S_KD;
      end
      S_KD: begin
        best_d   = best_nxt;
        best_k_d = best_k_nxt;
        if (k_last) begin
          // Advance to the next cell, to the next chain length, or to the results when the table is full
          if ((jp1_full + LW'(1)) > n_q) begin
            i_d   = '0;
            len_d = len_q + LW'(1);
            state_d = ((len_q + LW'(1)) > n_q) ? S_ERD : S_DI;
          end else begin
            i_d     = i_q + IW'(1);
            state_d = S_DI;
          end
        end else begin
          k_d     = kp1_idx;
          state_d = S_KA;
        end
      end
      S_ERD: state_d = S_ECAP;
      S_ECAP: begin
        row_d   = OW'(r_q);
        col_d   = OW'(c_q);
        split_d = (r_q == c_q) ? '0 : OW'(split_rdata);
        cost_d  = (r_q == c_q) ? '0 : mcod_pkg::COST_OUT_W'(cost_rdata);
        err_d   = 1'b0;
        last_d  = ((LW'(r_q) + LW'(1)) == n_q);
        state_d = S_EWAIT;
      end
      S_EWAIT: begin
        if (out_o.ready) begin
          if (last_q) begin
            state_d = S_LOAD;
          end else begin
            if ((LW'(c_q) + LW'(1)) == n_q) begin
              r_d = r_q + IW'(1);
              c_d = r_q + IW'(1);
            end else begin
              c_d = c_q + IW'(1);
            end
            state_d = S_ERD;
          end
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
    end
  end

  // Datapath and payload registers
  always_ff @(posedge clk_i) begin
    n_q      <= n_d;
    len_q    <= len_d;
    i_q      <= i_d;
    k_q      <= k_d;
    r_q      <= r_d;
    c_q      <= c_d;
    dim_i_q  <= dim_i_d;
    prod_q   <= prod_d;
    term_q   <= term_d;
    left_q   <= left_d;
    sum_q    <= sum_d;
    best_q   <= best_d;
    best_k_q <= best_k_d;
    row_q    <= row_d;
    col_q    <= col_d;
    split_q  <= split_d;
    cost_q   <= cost_d;
    err_q    <= err_d;
    last_q   <= last_d;
  end

  assign out_o.valid    = (state_q == S_EWAIT);
  assign out_o.row      = row_q;
  assign out_o.col      = col_q;
  assign out_o.split_at = split_q;
  assign out_o.min_cost = cost_q;
  assign out_o.error    = err_q;
  assign out_o.last     = last_q;

  mcod_ram #(
    .WIDTH (DW),
    .DEPTH (mcod_pkg::DIM_CAP)
  ) u_dim_ram (
    .clk_i   (clk_i),
    .we_i    (dim_we),
    .waddr_i (dim_waddr),
    .wdata_i (dim_wdata),
    .raddr_i (dim_raddr),
    .rdata_o (dim_rdata)
  );

  mcod_ram #(
    .WIDTH (CW),
    .DEPTH (mcod_pkg::CELL_DEPTH)
  ) u_cost_ram (
    .clk_i   (clk_i),
    .we_i    (cell_we),
    .waddr_i (cell_waddr),
    .wdata_i (cost_wdata),
    .raddr_i (cell_raddr),
    .rdata_o (cost_rdata)
  );

  mcod_ram #(
    .WIDTH (IW),
    .DEPTH (mcod_pkg::CELL_DEPTH)
  ) u_split_ram (
    .clk_i   (clk_i),
    .we_i    (cell_we),
    .waddr_i (cell_waddr),
    .wdata_i (best_k_nxt),
    .raddr_i (cell_raddr),
    .rdata_o (split_rdata)
  );

  // Never take an item while a result is pending
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_i.ready && out_o.valid))
    else $error("input ready while a result is pending");

  // Split candidates stay inside the subchain
  a_k_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_KA || state_q == S_KB || state_q == S_KC || state_q == S_KD)
    |-> (LW'(k_q) < j_full))
    else $error("split index outside subchain");

  // An error result carries zero fields and ends the run
  a_err_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.error) |->
    (out_o.row == '0 && out_o.col == '0 && out_o.split_at == '0 &&
     out_o.min_cost == '0 && out_o.last))
    else $error("error result with nonzero fields");

  // Cells come out with row not above col
  a_row_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.error) |-> (out_o.row <= out_o.col))
    else $error("result cell below diagonal");

  // After the final result the block loads again
  a_back_to_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && out_o.last) |=> in_i.ready)
    else $error("not ready after final result");

endmodule

// ----- tb/tb_matrix_chain_order_dp_core.sv -----
`timescale 1ns / 100ps

module tb_matrix_chain_order_dp_core;

  localparam int CLK_HALF   = 10;
  localparam int RST_CYCLES = 9;
  localparam int RAND_ITEMS = 345;
  localparam int LONG_HOLD  = 1000;
  localparam int DRAIN      = 200;
  localparam int CYCLE_CAP  = 1000000;
  localparam int PLAN_ROWS  = 25;

  typedef struct packed {
    logic [mcod_pkg::IDX_OUT_W-1:0]  row;
    logic [mcod_pkg::IDX_OUT_W-1:0]  col;
    logic [mcod_pkg::IDX_OUT_W-1:0]  split_at;
    logic [mcod_pkg::COST_OUT_W-1:0] min_cost;
    logic                            error;
    logic                            last;
  } cell_t;

  typedef struct {
    logic [mcod_pkg::DIM_IN_W-1:0] dim;
    bit                            fin;
    bit                            typed;
    cell_t                         want;
  } plan_row_t;

  localparam cell_t NO_CELL  = '0;
  localparam cell_t ERR_CELL = '{row: '0, col: '0, split_at: '0, min_cost: '0,
                                 error: 1'b1, last: 1'b1};
  localparam cell_t ONE_CELL = '{row: '0, col: '0, split_at: '0, min_cost: '0,
                                 error: 1'b0, last: 1'b1};

  logic clk_i;
  logic rst_ni;

  mcod_in_if  in_if ();
  mcod_out_if out_if ();

  matrix_chain_order_dp_core u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Chain state of the predictor
  mcod_pkg::dim_t chain_dims [mcod_pkg::DIM_CAP];
  int             chain_len;
  bit             chain_over;
  logic [63:0]    best_cost  [mcod_pkg::MAX_MATRICES][mcod_pkg::MAX_MATRICES];
  int             best_split [mcod_pkg::MAX_MATRICES][mcod_pkg::MAX_MATRICES];

  cell_t fresh_cells [$];
  cell_t due_cells [$];

  int  snd_idle_pct;
  int  rcv_idle_pct;
  bit  hold_out_req;
  int  items_sent;
  int  err_cnt;
  int  cycle_cnt;

  plan_row_t plan [PLAN_ROWS];

  // Clock
  initial clk_i = 1'b0;
  always #CLK_HALF clk_i = ~clk_i;

  // Store one dimension; on the final one solve the chain into fresh_cells
  function automatic void solve_chain_item(input logic [mcod_pkg::DIM_IN_W-1:0] d,
                                           input bit fin);
    int          n;
    int          len;
    int          i;
    int          j;
    int          k;
    int          pick_k;
    int          total;
    int          emitted;
    logic [63:0] c;
    logic [63:0] best;
    cell_t       res;
    fresh_cells.delete();
    if (chain_len < mcod_pkg::DIM_CAP) begin
      chain_dims[chain_len] = mcod_pkg::dim_t'(d);
      chain_len++;
    end else begin
      chain_over = 1'b1;
    end
    if (!fin) return;
    if (chain_over || chain_len < 2) begin
      chain_len  = 0;
      chain_over = 1'b0;
      fresh_cells.push_back(ERR_CELL);
      return;
    end
    n          = chain_len - 1;
    chain_len  = 0;
    chain_over = 1'b0;
    for (i = 0; i < n; i++) begin
      best_cost[i][i]  = '0;
      best_split[i][i] = 0;
    end
    // Fill by subchain length, keep the first k on ties
    for (len = 2; len <= n; len++) begin
      for (i = 0; i + len <= n; i++) begin
        j      = i + len - 1;
        best   = '0;
        pick_k = i;
        for (k = i; k < j; k++) begin
          c = best_cost[i][k] + best_cost[k+1][j]
            + 64'(chain_dims[i]) * 64'(chain_dims[k+1]) * 64'(chain_dims[j+1]);
          if (k == i || c < best) begin
            best   = c;
            pick_k = k;
          end
        end
        best_cost[i][j]  = best;
        best_split[i][j] = pick_k;
      end
    end
    // Emit the upper triangle row-major
    total   = n * (n + 1) / 2;
    emitted = 0;
    for (i = 0; i < n; i++) begin
      for (j = i; j < n; j++) begin
        res.row      = mcod_pkg::IDX_OUT_W'(i);
        res.col      = mcod_pkg::IDX_OUT_W'(j);
        res.split_at = mcod_pkg::IDX_OUT_W'(best_split[i][j]);
        res.min_cost = best_cost[i][j][mcod_pkg::COST_OUT_W-1:0];
        res.error    = 1'b0;
        res.last     = (emitted + 1 == total);
        fresh_cells.push_back(res);
        emitted++;
      end
    end
  endfunction

  function automatic logic [mcod_pkg::DIM_IN_W-1:0] pick_dim();
    int sel;
    sel = $urandom_range(99);
    if (sel < 8) return '0;
    if (sel < 16) return '1;
    if (sel < 50) return mcod_pkg::DIM_IN_W'($urandom_range(15, 1));
    return mcod_pkg::DIM_IN_W'($urandom_range((1 << mcod_pkg::DIM_IN_W) - 1, 0));
  endfunction

  // Offer one item, wait for acceptance, then queue what it causes
  task automatic offer_item(input logic [mcod_pkg::DIM_IN_W-1:0] d, input bit fin,
                            input bit typed, input cell_t typed_cell);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid    <= 1'b1;
    in_if.dim      <= d;
    in_if.last_dim <= fin;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    solve_chain_item(d, fin);
    if (typed) begin
      due_cells.push_back(typed_cell);
    end else begin
      foreach (fresh_cells[idx]) due_cells.push_back(fresh_cells[idx]);
    end
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic offer_chain(input int ndims);
    int idx;
    for (idx = 0; idx < ndims; idx++) offer_item(pick_dim(), idx == ndims - 1, 1'b0, NO_CELL);
  endtask

  // Mostly well-formed chains, biased short; some too short and some too long
  task automatic offer_random_chain();
    int kind;
    kind = $urandom_range(99);
    if (kind < 8) offer_chain(1);
    else if (kind < 18) offer_chain($urandom_range(mcod_pkg::DIM_CAP + 3,
                                                   mcod_pkg::DIM_CAP + 1));
    else if (kind < 40) offer_chain($urandom_range(mcod_pkg::DIM_CAP, 6));
    else offer_chain($urandom_range(5, 2));
  endtask

  // Drop valid and hold until every queued result has come out
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (due_cells.size() != 0) @(negedge clk_i);
  endtask

  // Receiver: random ready, or a long counted hold on request
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_out_req) begin
        out_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk_i);
        hold_out_req = 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  // Check each accepted result against the oldest expectation
  always @(posedge clk_i) begin
    cell_t got;
    cell_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = '{row: out_if.row, col: out_if.col, split_at: out_if.split_at,
              min_cost: out_if.min_cost, error: out_if.error, last: out_if.last};
      if (due_cells.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result row=%0d col=%0d split=%0d cost=%0d err=%0b last=%0b",
                 $time, got.row, got.col, got.split_at, got.min_cost, got.error, got.last);
      end else begin
        want = due_cells.pop_front();
        if (got !== want) begin
          err_cnt++;
          $display("%0t: mismatch expected row=%0d col=%0d split=%0d cost=%0d err=%0b last=%0b",
                   $time, want.row, want.col, want.split_at, want.min_cost, want.error,
                   want.last);
          $display("%0t:          actual   row=%0d col=%0d split=%0d cost=%0d err=%0b last=%0b",
                   $time, got.row, got.col, got.split_at, got.min_cost, got.error, got.last);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_CAP) begin
      $display("%0t: timeout with %0d results outstanding", $time, due_cells.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int r;
    int p;
    rst_ni         = 1'b0;
    in_if.valid    = 1'b0;
    in_if.dim      = '0;
    in_if.last_dim = 1'b0;
    hold_out_req   = 1'b0;
    snd_idle_pct   = 34;
    rcv_idle_pct   = 78;
    chain_len      = 0;
    chain_over     = 1'b0;
    items_sent     = 0;
    err_cnt        = 0;
    cycle_cnt      = 0;

    // Single dimension, one matrix, max-size chain, all-zero ties, overflow
    plan = '{
      '{12'd4095, 1'b1, 1'b1, ERR_CELL},
      '{12'd0,    1'b0, 1'b0, NO_CELL},
      '{12'd4095, 1'b1, 1'b1, ONE_CELL},
      '{12'd4095, 1'b0, 1'b0, NO_CELL},
      '{12'd4095, 1'b0, 1'b0, NO_CELL},
      '{12'd4095, 1'b0, 1'b0, NO_CELL},
      '{12'd4095, 1'b0, 1'b0, NO_CELL},
      '{12'd4095, 1'b0, 1'b0, NO_CELL},
      '{12'd4095, 1'b0, 1'b0, NO_CELL},
      '{12'd4095, 1'b0, 1'b0, NO_CELL},
      '{12'd4095, 1'b0, 1'b0, NO_CELL},
      '{12'd4095, 1'b1, 1'b0, NO_CELL},
      '{12'd0,    1'b0, 1'b0, NO_CELL},
      '{12'd0,    1'b0, 1'b0, NO_CELL},
      '{12'd0,    1'b1, 1'b0, NO_CELL},
      '{12'd30,   1'b0, 1'b0, NO_CELL},
      '{12'd35,   1'b0, 1'b0, NO_CELL},
      '{12'd15,   1'b0, 1'b0, NO_CELL},
      '{12'd5,    1'b0, 1'b0, NO_CELL},
      '{12'd10,   1'b0, 1'b0, NO_CELL},
      '{12'd20,   1'b0, 1'b0, NO_CELL},
      '{12'd25,   1'b0, 1'b0, NO_CELL},
      '{12'd2048, 1'b0, 1'b0, NO_CELL},
      '{12'd1,    1'b0, 1'b0, NO_CELL},
      '{12'd7,    1'b1, 1'b1, ERR_CELL}
    };

    // Reset
    repeat (RST_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed table
    for (r = 0; r < PLAN_ROWS; r++) begin
      offer_item(plan[r].dim, plan[r].fin, plan[r].typed, plan[r].want);
    end
    wait_drained();

    // Random chains over three idling phases
    for (p = 0; p < 3; p++) begin
      case (p)
        0: begin
          snd_idle_pct = 34;
          rcv_idle_pct = 78;
        end
        1: begin
          snd_idle_pct = 78;
          rcv_idle_pct = 34;
        end
        default: begin
          snd_idle_pct = 0;
          rcv_idle_pct = 0;
          // Stall the output while a full chain and the next one are offered
          hold_out_req = 1'b1;
          offer_chain(mcod_pkg::DIM_CAP);
        end
      endcase
      while (items_sent < PLAN_ROWS + (p + 1) * RAND_ITEMS / 3) offer_random_chain();
      wait_drained();
    end

    repeat (DRAIN) @(posedge clk_i);
    if (err_cnt == 0 && due_cells.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- matrix_chain_order_dp_core.f -----
sv/mcod_pkg.sv
sv/mcod_ifs.sv
sv/mcod_ram.sv
sv/matrix_chain_order_dp_core.sv
tb/tb_matrix_chain_order_dp_core.sv
